// ===== hw/rtl/rmq_pkg.sv =====
package rmq_pkg;

  // Number format of matrix elements and quaternion components.
  localparam int FRAC_BITS = 16;
  localparam int DW        = 18;

  // Signed width of trace and radicand terms; radicand stays below 2^(SR_W-1).
  localparam int SR_W = ((FRAC_BITS + 2 > 20) ? FRAC_BITS + 2 : 20) + 1;
  // Width of the sqrt operand (radicand << FRAC_BITS), rounded up to even.
  localparam int N_W  = SR_W - 1 + FRAC_BITS;
  localparam int S_W  = (N_W + 1) / 2;
  localparam int NP   = 2 * S_W;

  // Off-diagonal sums and differences: signed width and magnitude width.
  localparam int DS_W  = DW + 1;
  localparam int MAG_W = DW + 1;

  // Divider: dividend (mag << FRAC_BITS) + s, quotient bits kept.
  localparam int DV_W = MAG_W + FRAC_BITS + 1;
  localparam int Q_W  = DW;
  localparam int CW   = (DV_W > S_W + 1 + Q_W) ? DV_W : S_W + 1 + Q_W;

  // Pipeline registers from an accepted request to its result.
  localparam int LATENCY = 2 + S_W + 1 + Q_W + 1;

  localparam logic signed [SR_W-1:0] ONE_S = SR_W'(1) << FRAC_BITS;
  localparam logic [DW-1:0] OUT_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] OUT_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic [S_W-1:0] HALF_MAX = S_W'(OUT_POS);

  // Which output slot takes the half square root.
  typedef enum logic [1:0] {
    H_W = 2'd0,
    H_X = 2'd1,
    H_Y = 2'd2,
    H_Z = 2'd3
  } hsel_e;

  // Largest diagonal element.
  typedef enum logic [1:0] {
    AX_0 = 2'd0,
    AX_1 = 2'd1,
    AX_2 = 2'd2
  } axis_e;

  // Item inside the square root stages.
  typedef struct packed {
    logic [NP-1:0]           n;
    logic [S_W+1:0]          rem;
    logic [S_W-1:0]          root;
    logic [2:0]              neg;
    logic [2:0][MAG_W-1:0]   mag;
    hsel_e                   hsel;
    logic                    zero;
  } sq_t;

  // Item inside the divider stages.
  typedef struct packed {
    logic [S_W:0]            den;
    logic [2:0][CW-1:0]      rem;
    logic [2:0][Q_W-1:0]     quo;
    logic [2:0]              sat;
    logic [2:0]              neg;
    logic [DW-2:0]           half;
    hsel_e                   hsel;
    logic                    zero;
  } dv_t;

endpackage

// ===== hw/rtl/rmq_front.sv =====
module rmq_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic signed [rmq_pkg::DW-1:0] m00_i,
  input  logic signed [rmq_pkg::DW-1:0] m01_i,
  input  logic signed [rmq_pkg::DW-1:0] m02_i,
  input  logic signed [rmq_pkg::DW-1:0] m10_i,
  input  logic signed [rmq_pkg::DW-1:0] m11_i,
  input  logic signed [rmq_pkg::DW-1:0] m12_i,
  input  logic signed [rmq_pkg::DW-1:0] m20_i,
  input  logic signed [rmq_pkg::DW-1:0] m21_i,
  input  logic signed [rmq_pkg::DW-1:0] m22_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output rmq_pkg::sq_t              item_o
);
  import rmq_pkg::*;

  typedef struct packed {
    logic signed [SR_W-1:0] trace;
    logic signed [DW-1:0]   d0;
    logic signed [DW-1:0]   d1;
    logic signed [DW-1:0]   d2;
    axis_e                  axis;
    logic signed [DS_W-1:0] dw0;
    logic signed [DS_W-1:0] dw1;
    logic signed [DS_W-1:0] dw2;
    logic signed [DS_W-1:0] s01;
    logic signed [DS_W-1:0] s02;
    logic signed [DS_W-1:0] s12;
  } fa_t;

  fa_t  a_d, a_q;
  logic a_v_q, a_stall;
  sq_t  b_d, b_q;
  logic b_v_q;
  logic signed [DW-1:0] dmax;
  logic signed [SR_W-1:0] di, dj, dk, rad;
  logic signed [DS_W-1:0] l0, l1, l2;

  assign a_stall = a_v_q && b_v_q && stall_i;
  assign stall_o = a_stall;
  assign valid_o = b_v_q;
  assign item_o  = b_q;

  // First stage: trace, largest diagonal, off-diagonal sums and differences.
  always_comb begin
    a_d.trace = SR_W'(m00_i) + SR_W'(m11_i) + SR_W'(m22_i);
    a_d.d0 = m00_i;
    a_d.d1 = m11_i;
    a_d.d2 = m22_i;
    dmax = (m11_i > m00_i) ? m11_i : m00_i;
    if (m22_i > dmax) begin
      a_d.axis = AX_2;
    end else if (m11_i > m00_i) begin
      a_d.axis = AX_1;
    end else begin
      a_d.axis = AX_0;
    end
    a_d.dw0 = DS_W'(m21_i) - DS_W'(m12_i);
    a_d.dw1 = DS_W'(m02_i) - DS_W'(m20_i);
    a_d.dw2 = DS_W'(m10_i) - DS_W'(m01_i);
    a_d.s01 = DS_W'(m01_i) + DS_W'(m10_i);
    a_d.s02 = DS_W'(m02_i) + DS_W'(m20_i);
    a_d.s12 = DS_W'(m12_i) + DS_W'(m21_i);
  end

  // Second stage: radicand, branch, lanes routed to the divider.
  always_comb begin
    di = SR_W'(a_q.d0);
    dj = SR_W'(a_q.d1);
    dk = SR_W'(a_q.d2);
    l0 = a_q.dw0;
    l1 = a_q.dw1;
    l2 = a_q.dw2;
    b_d.hsel = H_W;
    if (a_q.trace > 0) begin
      rad = a_q.trace + ONE_S;
    end else begin
      case (a_q.axis)
        AX_0: begin
          di = SR_W'(a_q.d0); dj = SR_W'(a_q.d1); dk = SR_W'(a_q.d2);
          b_d.hsel = H_X;
          l0 = a_q.dw0; l1 = a_q.s01; l2 = a_q.s02;
        end
        AX_1: begin
          di = SR_W'(a_q.d1); dj = SR_W'(a_q.d2); dk = SR_W'(a_q.d0);
          b_d.hsel = H_Y;
          l0 = a_q.dw1; l1 = a_q.s01; l2 = a_q.s12;
        end
        AX_2: begin
          di = SR_W'(a_q.d2); dj = SR_W'(a_q.d0); dk = SR_W'(a_q.d1);
          b_d.hsel = H_Z;
          l0 = a_q.dw2; l1 = a_q.s02; l2 = a_q.s12;
        end
        default: begin
          di = SR_W'(a_q.d0); dj = SR_W'(a_q.d1); dk = SR_W'(a_q.d2);
          b_d.hsel = H_X;
          l0 = a_q.dw0; l1 = a_q.s01; l2 = a_q.s02;
        end
      endcase
      rad = di - (dj + dk) + ONE_S;
    end
    b_d.zero = (rad <= 0);
    b_d.n    = b_d.zero ? '0 : NP'(rad[SR_W-2:0]) << FRAC_BITS;
    b_d.rem  = '0;
    b_d.root = '0;
    b_d.neg  = {l2[DS_W-1], l1[DS_W-1], l0[DS_W-1]};
    b_d.mag[0] = l0[DS_W-1] ? MAG_W'(-l0) : MAG_W'(l0);
    b_d.mag[1] = l1[DS_W-1] ? MAG_W'(-l1) : MAG_W'(l1);
    b_d.mag[2] = l2[DS_W-1] ? MAG_W'(-l2) : MAG_W'(l2);
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (!a_stall) begin
        a_v_q <= valid_i;
      end
      if (!(b_v_q && stall_i)) begin
        b_v_q <= a_v_q;
      end
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk_i) begin
    if (!a_stall) begin
      a_q <= a_d;
    end
    if (!(b_v_q && stall_i)) begin
      b_q <= b_d;
    end
  end

endmodule

// ===== hw/rtl/rmq_sqrt_stage.sv =====
module rmq_sqrt_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         stall_o,
  input  rmq_pkg::sq_t item_i,
  output logic         valid_o,
  input  logic         stall_i,
  output rmq_pkg::sq_t item_o
);
  import rmq_pkg::*;

  sq_t  d, q;
  logic v_q;
  logic [S_W+3:0] acc, trial;

  assign stall_o = v_q && stall_i;
  assign valid_o = v_q;
  assign item_o  = q;

  // One root bit per stage: bring down two operand bits and try the subtract.
  always_comb begin
    d     = item_i;
    acc   = {item_i.rem, item_i.n[NP-1 -: 2]};
    trial = {2'b00, item_i.root, 2'b01};
    d.n   = {item_i.n[NP-3:0], 2'b00};
    if (acc >= trial) begin
      d.rem  = (S_W+2)'(acc - trial);
      d.root = {item_i.root[S_W-2:0], 1'b1};
    end else begin
      d.rem  = acc[S_W+1:0];
      d.root = {item_i.root[S_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!stall_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      q <= d;
    end
  end

endmodule

// ===== hw/rtl/rmq_div_stage.sv =====
module rmq_div_stage #(
  parameter int BIT = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         stall_o,
  input  rmq_pkg::dv_t item_i,
  output logic         valid_o,
  input  logic         stall_i,
  output rmq_pkg::dv_t item_o
);
  import rmq_pkg::*;

  dv_t  d, q;
  logic v_q;
  logic [CW-1:0] dsh;

  assign stall_o = v_q && stall_i;
  assign valid_o = v_q;
  assign item_o  = q;

  // One quotient bit per stage for all three lanes.
  always_comb begin
    d   = item_i;
    dsh = CW'(item_i.den) << BIT;
    for (int l = 0; l < 3; l++) begin
      if (item_i.rem[l] >= dsh) begin
        d.rem[l]      = item_i.rem[l] - dsh;
        d.quo[l][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!stall_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      q <= d;
    end
  end

endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Pipeline from an accepted request to its quaternion: two front stages, one
// per square root bit, one divider setup, one per quotient bit, and output.
// Throughput: one matrix per cycle; each stage holds while the one after it is
// full and stalled, so bubbles close up and the input stalls only when all are full.
// Reset: rst_ni clears all valid bits asynchronously; payload registers are not reset.
module rotation_matrix_to_quaternion (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [rmq_pkg::DW-1:0] m00_i,
  input  logic signed [rmq_pkg::DW-1:0] m01_i,
  input  logic signed [rmq_pkg::DW-1:0] m02_i,
  input  logic signed [rmq_pkg::DW-1:0] m10_i,
  input  logic signed [rmq_pkg::DW-1:0] m11_i,
  input  logic signed [rmq_pkg::DW-1:0] m12_i,
  input  logic signed [rmq_pkg::DW-1:0] m20_i,
  input  logic signed [rmq_pkg::DW-1:0] m21_i,
  input  logic signed [rmq_pkg::DW-1:0] m22_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [rmq_pkg::DW-1:0] qw_o,
  output logic signed [rmq_pkg::DW-1:0] qx_o,
  output logic signed [rmq_pkg::DW-1:0] qy_o,
  output logic signed [rmq_pkg::DW-1:0] qz_o
);
  import rmq_pkg::*;

  sq_t  sq   [S_W+1];
  logic sq_v [S_W+1];
  logic sq_s [S_W+1];
  dv_t  dv   [Q_W+1];
  logic dv_v [Q_W+1];
  logic dv_s [Q_W+1];

  dv_t  cv_d, cv_q;
  logic cv_v_q;
  logic [CW-1:0] dvd;
  logic [S_W-1:0] hs;
  logic [2:0][DW-1:0] lane;
  logic [DW-1:0] hv;
  logic [DW-1:0] w_d, x_d, y_d, z_d;
  logic [DW-1:0] w_q, x_q, y_q, z_q;
  logic o_v_q, o_stall;

  // Radicand, branch choice and lane routing.
  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .m00_i   (m00_i),
    .m01_i   (m01_i),
    .m02_i   (m02_i),
    .m10_i   (m10_i),
    .m11_i   (m11_i),
    .m12_i   (m12_i),
    .m20_i   (m20_i),
    .m21_i   (m21_i),
    .m22_i   (m22_i),
    .valid_o (sq_v[0]),
    .stall_i (sq_s[0]),
    .item_o  (sq[0])
  );

  // Square root, one result bit per stage.
  for (genvar g = 0; g < S_W; g++) begin : g_sqrt
    rmq_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[g]),
      .stall_o (sq_s[g]),
      .item_i  (sq[g]),
      .valid_o (sq_v[g+1]),
      .stall_i (sq_s[g+1]),
      .item_o  (sq[g+1])
    );
  end

  // Divider setup: half root, divisor 2s, rounded dividends, overflow check.
  always_comb begin
    hs = S_W'(({1'b0, sq[S_W].root} + (S_W+1)'(1)) >> 1);
    cv_d.den  = {sq[S_W].root, 1'b0};
    cv_d.half = (hs > HALF_MAX) ? (DW-1)'(HALF_MAX) : (DW-1)'(hs);
    cv_d.neg  = sq[S_W].neg;
    cv_d.hsel = sq[S_W].hsel;
    cv_d.zero = sq[S_W].zero;
    cv_d.quo  = '0;
    for (int l = 0; l < 3; l++) begin
      dvd = (CW'(sq[S_W].mag[l]) << FRAC_BITS) + CW'(sq[S_W].root);
      cv_d.rem[l] = dvd;
      cv_d.sat[l] = (dvd >= (CW'(cv_d.den) << Q_W));
    end
  end

  assign sq_s[S_W] = cv_v_q && dv_s[0];
  assign dv_v[0]   = cv_v_q;
  assign dv[0]     = cv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_v_q <= 1'b0;
    end else if (!sq_s[S_W]) begin
      cv_v_q <= sq_v[S_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!sq_s[S_W]) begin
      cv_q <= cv_d;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar g = 0; g < Q_W; g++) begin : g_div
    rmq_div_stage #(
      .BIT (Q_W - 1 - g)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[g]),
      .stall_o (dv_s[g]),
      .item_i  (dv[g]),
      .valid_o (dv_v[g+1]),
      .stall_i (dv_s[g+1]),
      .item_o  (dv[g+1])
    );
  end

  // Sign, saturation and placement of the components; all zero when the radicand is not positive.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv[Q_W].neg[l]) begin
        lane[l] = (dv[Q_W].sat[l] || dv[Q_W].quo[l] > OUT_NEG) ? OUT_NEG
                : DW'(-dv[Q_W].quo[l]);
      end else begin
        lane[l] = (dv[Q_W].sat[l] || dv[Q_W].quo[l] > OUT_POS) ? OUT_POS
                : DW'(dv[Q_W].quo[l]);
      end
    end
    hv = {1'b0, dv[Q_W].half};
    case (dv[Q_W].hsel)
      H_W: begin
        w_d = hv;      x_d = lane[0]; y_d = lane[1]; z_d = lane[2];
      end
      H_X: begin
        w_d = lane[0]; x_d = hv;      y_d = lane[1]; z_d = lane[2];
      end
      H_Y: begin
        w_d = lane[0]; x_d = lane[1]; y_d = hv;      z_d = lane[2];
      end
      H_Z: begin
        w_d = lane[0]; x_d = lane[1]; y_d = lane[2]; z_d = hv;
      end
      default: begin
        w_d = hv;      x_d = lane[0]; y_d = lane[1]; z_d = lane[2];
      end
    endcase
    if (dv[Q_W].zero) begin
      w_d = '0; x_d = '0; y_d = '0; z_d = '0;
    end
  end

  assign o_stall    = o_v_q && out_stall_i;
  assign dv_s[Q_W]  = o_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (!o_stall) begin
      o_v_q <= dv_v[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!o_stall) begin
      w_q <= w_d;
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign out_valid_o = o_v_q;
  assign qw_o = w_q;
  assign qx_o = x_q;
  assign qy_o = y_q;
  assign qz_o = z_q;

endmodule

// ===== hw/rtl/rmq_checker.sv =====
module rmq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [rmq_pkg::DW-1:0] qw_o
);
  import rmq_pkg::*;

  localparam int CNT_W = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Requests inside the pipeline.
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A result is only shown for a request that went in.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result without a pending request");

  // The pipeline never holds more requests than it has stages.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LATENCY))
    else $error("more requests in flight than pipeline stages");

  // An empty pipeline never stalls its input.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> !in_stall_o)
    else $error("input stalled while pipeline is empty");

  // A stalled result stays valid, and its w component holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(qw_o))
    else $error("stalled result changed");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .qw_o        (qw_o)
);
